// File: design/bhpd_pkg.sv
// ----------------------------------------------------------------------------
// BMP deframer package
// Shared types and constants for the BMP header and pixel deframer.
// ----------------------------------------------------------------------------
package bhpd_pkg;

   localparam int ITEM_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH  = 4;

   localparam logic [7:0] SIG_B = 8'h42;
   localparam logic [7:0] SIG_M = 8'h4D;

   localparam int FILE_HDR_LEN  = 14;
   localparam int INFO_HDR_LEN  = 40;
   localparam int PALETTE_START = 32;
   localparam int DEPTH_24      = 24;
   localparam int DEPTH_32      = 32;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_FILEHDR,
      PH_INFO,
      PH_SKIP,
      PH_PIXELS
   } phase_type;

   typedef enum logic [1:0] {
      OP_BYTE,
      OP_START,
      OP_END
   } item_op_type;

   typedef enum logic [1:0] {
      KIND_PIXEL    = 2'd0,
      KIND_HEADER   = 2'd1,
      KIND_COMPLETE = 2'd2,
      KIND_ERROR    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_SIGNATURE = 3'd1,
      ERR_OFFSET    = 3'd2,
      ERR_SIZE      = 3'd3,
      ERR_PLANES    = 3'd4,
      ERR_DEPTH     = 3'd5,
      ERR_PALETTE   = 3'd6,
      ERR_TRUNCATED = 3'd7
   } err_type;

   typedef struct packed {
      item_op_type op;
      logic [7:0]  data;
   } item_type;

   typedef struct packed {
      kind_type    kind;
      logic [11:0] column;
      logic [11:0] row;
      logic [31:0] color;
      logic [12:0] width;
      logic [12:0] height;
      logic [2:0]  bpp;
      err_type     err;
      logic        last;
   } result_type;

endpackage

// File: design/bhpd_front.sv
// ----------------------------------------------------------------------------
// BMP deframer front end
// Accepts input items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module bhpd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_start_of_file,
   input  logic                req_end_of_file,
   output logic                item_valid,
   output bhpd_pkg::item_type  item,
   input  logic                item_take
);

   localparam int Depth = bhpd_pkg::ITEM_QUEUE_DEPTH;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   bhpd_pkg::item_type slot_ff [Depth];
   bhpd_pkg::item_type item_class;
   logic [PtrW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               push;

   assign req_stall  = (count_ff == CntW'(Depth));
   assign push       = req_valid & ~req_stall;
   assign item_valid = (count_ff != '0);
   assign item       = slot_ff[rd_ff];

   // An end of stream outranks a start of file on the same item.
   always_comb begin
      item_class.data = req_data_byte;
      priority if (req_end_of_file) begin
         item_class.op = bhpd_pkg::OP_END;
      end else if (req_start_of_file) begin
         item_class.op = bhpd_pkg::OP_START;
      end else begin
         item_class.op = bhpd_pkg::OP_BYTE;
      end
   end

   always_comb begin
      wr_in    = push ? PtrW'((wr_ff + PtrW'(1)) % Depth) : wr_ff;
      rd_in    = item_take ? PtrW'((rd_ff + PtrW'(1)) % Depth) : rd_ff;
      count_in = count_ff + CntW'(push) - CntW'(item_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= item_class;
      end
   end

endmodule

// File: design/bhpd_parse.sv
// ----------------------------------------------------------------------------
// BMP deframer parser
// Walks and validates headers, assembles pixels; one item a cycle if out_room.
// ----------------------------------------------------------------------------
module bhpd_parse #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  bhpd_pkg::item_type   item,
   output logic                 item_take,
   input  logic                 out_room,
   output logic [1:0]           res_we,
   output bhpd_pkg::result_type res [2]
);

   localparam int ColW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
   localparam int RowW = ($clog2(MAX_HEIGHT + 1) > 12) ? $clog2(MAX_HEIGHT + 1) : 12;

   bhpd_pkg::phase_type phase_ff, phase_in, eff_phase;
   logic [31:0]         pos_ff, pos_in, eff_pos, pos_inc;
   logic                sig_ff, sig_in, eff_sig;
   logic                pal_ff, pal_in, eff_pal;
   logic [31:0]         offset_ff, offset_in;
   logic [31:0]         info_ff, info_in;
   logic [31:0]         width_ff, width_in;
   logic [31:0]         height_ff, height_in;
   logic [15:0]         planes_ff, planes_in;
   logic [15:0]         depth_ff, depth_in;
   logic [ColW-1:0]     col_ff, col_in, col_next;
   logic [RowW-1:0]     row_ff, row_in, row_next;
   logic [1:0]          bip_ff, bip_in;
   logic [31:0]         color_ff, color_in, color_new;
   logic [1:0]          pad_ff, pad_in, row_pad;
   logic                is32, pixel_done, do_validate, do_end_row;
   logic [7:0]          data;
   bhpd_pkg::err_type   base_err, val_err;

   function automatic logic [31:0] put_byte(input logic [31:0] word,
                                            input logic [1:0] lane,
                                            input logic [7:0] b);
      logic [31:0] r;
      r = word;
      r[lane*8 +: 8] = b;
      return r;
   endfunction

   function automatic bhpd_pkg::result_type blank_result(input bhpd_pkg::kind_type k);
      bhpd_pkg::result_type r;
      r      = '0;
      r.kind = k;
      r.err  = bhpd_pkg::ERR_NONE;
      return r;
   endfunction

   assign item_take = item_valid & out_room;
   assign data      = item.data;
   assign eff_phase = (item.op == bhpd_pkg::OP_START) ? bhpd_pkg::PH_FILEHDR : phase_ff;
   assign eff_pos   = (item.op == bhpd_pkg::OP_START) ? '0 : pos_ff;
   assign eff_sig   = (item.op == bhpd_pkg::OP_START) ? 1'b0 : sig_ff;
   assign eff_pal   = (item.op == bhpd_pkg::OP_START) ? 1'b0 : pal_ff;
   assign pos_inc   = eff_pos + 32'd1;

   assign is32       = (depth_ff == 16'(bhpd_pkg::DEPTH_32));
   assign row_pad    = is32 ? 2'd0 : width_ff[1:0];
   assign color_new  = put_byte(color_ff, bip_ff, data);
   assign pixel_done = (bip_ff == (is32 ? 2'd3 : 2'd2));
   assign col_next   = col_ff + ColW'(1);
   assign row_next   = row_ff + RowW'(1);

   always_comb begin
      priority if (sig_ff) begin
         base_err = bhpd_pkg::ERR_SIGNATURE;
      end else if ({1'b0, offset_ff} != 33'(bhpd_pkg::FILE_HDR_LEN) + {1'b0, info_ff}) begin
         base_err = bhpd_pkg::ERR_OFFSET;
      end else if (width_ff == '0 || width_ff > 32'(MAX_WIDTH) ||
                   height_ff == '0 || height_ff > 32'(MAX_HEIGHT)) begin
         base_err = bhpd_pkg::ERR_SIZE;
      end else if (planes_ff != 16'd1) begin
         base_err = bhpd_pkg::ERR_PLANES;
      end else if (depth_ff != 16'(bhpd_pkg::DEPTH_24) &&
                   depth_ff != 16'(bhpd_pkg::DEPTH_32)) begin
         base_err = bhpd_pkg::ERR_DEPTH;
      end else begin
         base_err = bhpd_pkg::ERR_NONE;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      sig_in      = sig_ff;
      pal_in      = pal_ff;
      offset_in   = offset_ff;
      info_in     = info_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      planes_in   = planes_ff;
      depth_in    = depth_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      bip_in      = bip_ff;
      color_in    = color_ff;
      pad_in      = pad_ff;
      do_validate = 1'b0;
      do_end_row  = 1'b0;
      val_err     = bhpd_pkg::ERR_NONE;
      res_we      = 2'b00;
      res[0]      = blank_result(bhpd_pkg::KIND_PIXEL);
      res[1]      = blank_result(bhpd_pkg::KIND_PIXEL);

      if (item_take) begin
         unique case (item.op)
            bhpd_pkg::OP_END: begin
               if (phase_ff != bhpd_pkg::PH_IDLE) begin
                  phase_in   = bhpd_pkg::PH_IDLE;
                  res_we     = 2'b01;
                  res[0]     = blank_result(bhpd_pkg::KIND_ERROR);
                  res[0].err = bhpd_pkg::ERR_TRUNCATED;
               end
            end
            bhpd_pkg::OP_START, bhpd_pkg::OP_BYTE: begin
               phase_in = eff_phase;
               sig_in   = eff_sig;
               pal_in   = eff_pal;
               unique case (eff_phase)
                  bhpd_pkg::PH_FILEHDR: begin
                     if ((eff_pos == 32'd0 && data != bhpd_pkg::SIG_B) ||
                         (eff_pos == 32'd1 && data != bhpd_pkg::SIG_M)) begin
                        sig_in = 1'b1;
                     end
                     if (eff_pos >= 32'd10 && eff_pos <= 32'd13) begin
                        offset_in = put_byte(offset_ff, 2'(eff_pos[1:0] - 2'd2), data);
                     end
                     pos_in = pos_inc;
                     if (pos_inc >= 32'(bhpd_pkg::FILE_HDR_LEN)) begin
                        pos_in   = '0;
                        phase_in = bhpd_pkg::PH_INFO;
                     end
                  end
                  bhpd_pkg::PH_INFO: begin
                     priority if (eff_pos <= 32'd3) begin
                        info_in = put_byte(info_ff, eff_pos[1:0], data);
                     end else if (eff_pos <= 32'd7) begin
                        width_in = put_byte(width_ff, eff_pos[1:0], data);
                     end else if (eff_pos <= 32'd11) begin
                        height_in = put_byte(height_ff, eff_pos[1:0], data);
                     end else if (eff_pos <= 32'd13) begin
                        if (eff_pos[0]) begin
                           planes_in[15:8] = data;
                        end else begin
                           planes_in[7:0] = data;
                        end
                     end else if (eff_pos <= 32'd15) begin
                        if (eff_pos[0]) begin
                           depth_in[15:8] = data;
                        end else begin
                           depth_in[7:0] = data;
                        end
                     end else if (eff_pos >= 32'(bhpd_pkg::PALETTE_START) &&
                                  data != 8'd0) begin
                        pal_in = 1'b1;
                     end else begin
                        pal_in = eff_pal;
                     end
                     pos_in = pos_inc;
                     if (pos_inc >= 32'(bhpd_pkg::INFO_HDR_LEN)) begin
                        if (info_ff > 32'(bhpd_pkg::INFO_HDR_LEN)) begin
                           phase_in = bhpd_pkg::PH_SKIP;
                        end else begin
                           do_validate = 1'b1;
                        end
                     end
                  end
                  bhpd_pkg::PH_SKIP: begin
                     pos_in = pos_inc;
                     if (pos_inc >= info_ff) begin
                        do_validate = 1'b1;
                     end
                  end
                  bhpd_pkg::PH_PIXELS: begin
                     if (pad_ff != 2'd0) begin
                        pad_in = pad_ff - 2'd1;
                        if (pad_ff == 2'd1) begin
                           do_end_row = 1'b1;
                        end
                     end else if (pixel_done) begin
                        res_we        = 2'b01;
                        res[0]        = blank_result(bhpd_pkg::KIND_PIXEL);
                        res[0].column = col_ff[11:0];
                        res[0].row    = row_ff[11:0];
                        res[0].color  = color_new;
                        color_in      = '0;
                        bip_in        = 2'd0;
                        col_in        = col_next;
                        if (col_next >= width_ff[ColW-1:0]) begin
                           if (row_pad != 2'd0) begin
                              pad_in = row_pad;
                           end else begin
                              do_end_row = 1'b1;
                           end
                        end
                     end else begin
                        color_in = color_new;
                        bip_in   = bip_ff + 2'd1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase

         if (do_validate) begin
            val_err = (base_err != bhpd_pkg::ERR_NONE) ? base_err :
                      (pal_in ? bhpd_pkg::ERR_PALETTE : bhpd_pkg::ERR_NONE);
            res_we = 2'b01;
            if (val_err != bhpd_pkg::ERR_NONE) begin
               phase_in   = bhpd_pkg::PH_IDLE;
               res[0]     = blank_result(bhpd_pkg::KIND_ERROR);
               res[0].err = val_err;
            end else begin
               phase_in      = bhpd_pkg::PH_PIXELS;
               col_in        = '0;
               row_in        = '0;
               bip_in        = 2'd0;
               color_in      = '0;
               pad_in        = 2'd0;
               res[0]        = blank_result(bhpd_pkg::KIND_HEADER);
               res[0].width  = width_ff[12:0];
               res[0].height = height_ff[12:0];
               res[0].bpp    = is32 ? 3'd4 : 3'd3;
            end
         end

         if (do_end_row) begin
            col_in = '0;
            row_in = row_next;
            if (row_next >= height_ff[RowW-1:0]) begin
               phase_in = bhpd_pkg::PH_IDLE;
               if (res_we[0]) begin
                  res_we = 2'b11;
                  res[1] = blank_result(bhpd_pkg::KIND_COMPLETE);
               end else begin
                  res_we = 2'b01;
                  res[0] = blank_result(bhpd_pkg::KIND_COMPLETE);
               end
            end
         end

         if (res_we[1]) begin
            res[1].last = 1'b1;
         end else begin
            res[0].last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bhpd_pkg::PH_IDLE;
         pos_ff   <= '0;
         sig_ff   <= 1'b0;
         pal_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         sig_ff   <= sig_in;
         pal_ff   <= pal_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      info_ff   <= info_in;
      width_ff  <= width_in;
      height_ff <= height_in;
      planes_ff <= planes_in;
      depth_ff  <= depth_in;
      col_ff    <= col_in;
      row_ff    <= row_in;
      bip_ff    <= bip_in;
      color_ff  <= color_in;
      pad_ff    <= pad_in;
   end

endmodule

// File: design/bhpd_rsp_queue.sv
// ----------------------------------------------------------------------------
// BMP deframer result queue
// Takes up to two parser results a cycle; gives one a cycle unless stalled.
// ----------------------------------------------------------------------------
module bhpd_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           res_we,
   input  bhpd_pkg::result_type res [2],
   output logic                 out_room,
   output logic                 rsp_valid,
   output bhpd_pkg::result_type rsp,
   input  logic                 rsp_stall
);

   localparam int Depth = bhpd_pkg::RSP_QUEUE_DEPTH;
   localparam int PtrW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   bhpd_pkg::result_type slot_ff [Depth];
   logic [PtrW-1:0]      wr_ff, wr_in, wr_second, rd_ff, rd_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic                 pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp       = slot_ff[rd_ff];
   assign pop       = rsp_valid & ~rsp_stall;
   assign out_room  = (count_ff <= CntW'(Depth - 2));
   assign wr_second = PtrW'((wr_ff + PtrW'(1)) % Depth);

   always_comb begin
      wr_in    = PtrW'((wr_ff + PtrW'(res_we[0]) + PtrW'(res_we[1])) % Depth);
      rd_in    = pop ? PtrW'((rd_ff + PtrW'(1)) % Depth) : rd_ff;
      count_in = count_ff + CntW'(res_we[0]) + CntW'(res_we[1]) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_we[0]) begin
         slot_ff[wr_ff] <= res[0];
      end
      if (res_we[1]) begin
         slot_ff[wr_second] <= res[1];
      end
   end

endmodule

// File: design/bmp_header_and_pixel_deframer.sv
// ----------------------------------------------------------------------------
// BMP header and pixel deframer
// Parses a 24 or 32 bit BMP byte stream into header, pixel and status items.
// ----------------------------------------------------------------------------
// The req channel carries one file byte per item, with start_of_file marking
// the first byte of a file and end_of_file marking the end of the stream (no
// byte). The rsp channel carries pixel items with their row and column, a
// header-accepted item with width, height and bytes per pixel, an
// image-complete item, or an error item with its code. The last flag marks
// the final rsp item caused by one req item; one req item causes at most two.
// Throughput is one req item per cycle while rsp is not stalled. An accepted
// req item passes through the two-entry input queue and then the four-entry
// result queue before it shows up on rsp. The parser takes an item only while
// the result queue has room for two results; a row end that yields both a
// pixel and image-complete puts two items into the result queue at once.
// When rsp is stalled the result queue fills, then the parser holds, then
// req_stall rises once the input queue is full. Reset empties both queues and
// puts the parser idle; bytes are ignored until a start of file arrives.
// ----------------------------------------------------------------------------
module bmp_header_and_pixel_deframer #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_file,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [11:0] rsp_pixel_column,
   output logic [11:0] rsp_pixel_row,
   output logic [31:0] rsp_pixel_color,
   output logic [12:0] rsp_image_width,
   output logic [12:0] rsp_image_height,
   output logic [2:0]  rsp_bytes_per_pixel,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last
);

   bhpd_pkg::item_type   item;
   bhpd_pkg::result_type res [2];
   bhpd_pkg::result_type rsp;
   logic                 item_valid, item_take, out_room;
   logic [1:0]           res_we;

   bhpd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_start_of_file (req_start_of_file),
      .req_end_of_file   (req_end_of_file),
      .item_valid        (item_valid),
      .item              (item),
      .item_take         (item_take)
   );

   bhpd_parse #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .out_room   (out_room),
      .res_we     (res_we),
      .res        (res)
   );

   bhpd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .res_we    (res_we),
      .res       (res),
      .out_room  (out_room),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_stall (rsp_stall)
   );

   assign rsp_kind            = rsp.kind;
   assign rsp_pixel_column    = rsp.column;
   assign rsp_pixel_row       = rsp.row;
   assign rsp_pixel_color     = rsp.color;
   assign rsp_image_width     = rsp.width;
   assign rsp_image_height    = rsp.height;
   assign rsp_bytes_per_pixel = rsp.bpp;
   assign rsp_error_code      = rsp.err;
   assign rsp_last            = rsp.last;

   a_res_needs_item: assert property (@(posedge clock) disable iff (reset)
      (res_we != 2'b00) |-> item_take)
      else $error("Result written without an item taken.");

   a_pair_is_pixel_then_done: assert property (@(posedge clock) disable iff (reset)
      res_we[1] |-> (res_we[0] && res[0].kind == bhpd_pkg::KIND_PIXEL &&
                     res[1].kind == bhpd_pkg::KIND_COMPLETE && res[1].last &&
                     !res[0].last))
      else $error("Two results in one cycle are not a pixel then image complete.");

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      (res_we == 2'b01) |-> res[0].last)
      else $error("Single result for an item lacks the last flag.");

   a_idle_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_valid && !req_stall))
      else $error("Queues not empty after reset.");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// BMP header and pixel deframer testbench
// Streams directed and random BMP files through the deframer and checks every
// result item against a cycle-free model of the parser kept in this module.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned MAX_W = 4096;
   localparam int unsigned MAX_H = 4096;
   localparam int QUIET_LIMIT = 1000;

   typedef struct {
      logic [7:0]  sig0;
      logic [7:0]  sig1;
      logic [31:0] offset;
      logic [31:0] info_len;
      logic [31:0] width;
      logic [31:0] height;
      logic [15:0] planes;
      logic [15:0] bits;
      logic [63:0] palette;
      int          data_len;
   } bmp_header_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_start_of_file = 1'b0;
   logic        req_end_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [11:0] rsp_pixel_column;
   logic [11:0] rsp_pixel_row;
   logic [31:0] rsp_pixel_color;
   logic [12:0] rsp_image_width;
   logic [12:0] rsp_image_height;
   logic [2:0]  rsp_bytes_per_pixel;
   logic [2:0]  rsp_error_code;
   logic        rsp_last;

   bit                   idling_on = 1'b0;
   int                   error_count = 0;
   int                   busy_items = 0;
   int                   stall_left = 0;
   bhpd_pkg::result_type decoded_items[$];

   bhpd_pkg::phase_type ph = bhpd_pkg::PH_IDLE;
   int unsigned hdr_pos;
   logic [31:0] data_ofs;
   logic [31:0] info_len;
   logic [31:0] img_w;
   logic [31:0] img_h;
   logic [15:0] n_planes;
   logic [15:0] n_bits;
   logic        sig_bad;
   logic        pal_bad;
   logic [31:0] col_cnt;
   logic [31:0] row_cnt;
   int unsigned byte_cnt;
   int unsigned pad_cnt;
   logic [31:0] color_acc;

   bmp_header_and_pixel_deframer #(
      .MAX_WIDTH (MAX_W),
      .MAX_HEIGHT(MAX_H)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_start_of_file  (req_start_of_file),
      .req_end_of_file    (req_end_of_file),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_pixel_column   (rsp_pixel_column),
      .rsp_pixel_row      (rsp_pixel_row),
      .rsp_pixel_color    (rsp_pixel_color),
      .rsp_image_width    (rsp_image_width),
      .rsp_image_height   (rsp_image_height),
      .rsp_bytes_per_pixel(rsp_bytes_per_pixel),
      .rsp_error_code     (rsp_error_code),
      .rsp_last           (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bhpd_pkg::result_type blank_record(bhpd_pkg::kind_type k);
      bhpd_pkg::result_type r;
      r = '0;
      r.kind = k;
      return r;
   endfunction

   function automatic void clear_parser();
      ph = bhpd_pkg::PH_IDLE;
      hdr_pos = 0;
      data_ofs = '0;
      info_len = '0;
      img_w = '0;
      img_h = '0;
      n_planes = '0;
      n_bits = '0;
      sig_bad = 1'b0;
      pal_bad = 1'b0;
      col_cnt = '0;
      row_cnt = '0;
      byte_cnt = 0;
      pad_cnt = 0;
      color_acc = '0;
   endfunction

   function automatic bhpd_pkg::result_type judge_headers();
      bhpd_pkg::err_type    code;
      bhpd_pkg::result_type r;
      code = bhpd_pkg::ERR_NONE;
      if (sig_bad)
         code = bhpd_pkg::ERR_SIGNATURE;
      else if (33'(data_ofs) != 33'(info_len) + 33'(bhpd_pkg::FILE_HDR_LEN))
         code = bhpd_pkg::ERR_OFFSET;
      else if (img_w == 0 || img_w > MAX_W || img_h == 0 || img_h > MAX_H)
         code = bhpd_pkg::ERR_SIZE;
      else if (n_planes != 1)
         code = bhpd_pkg::ERR_PLANES;
      else if (n_bits != bhpd_pkg::DEPTH_24 && n_bits != bhpd_pkg::DEPTH_32)
         code = bhpd_pkg::ERR_DEPTH;
      else if (pal_bad)
         code = bhpd_pkg::ERR_PALETTE;
      if (code != bhpd_pkg::ERR_NONE) begin
         ph = bhpd_pkg::PH_IDLE;
         r = blank_record(bhpd_pkg::KIND_ERROR);
         r.err = code;
      end else begin
         ph = bhpd_pkg::PH_PIXELS;
         col_cnt = '0;
         row_cnt = '0;
         byte_cnt = 0;
         pad_cnt = 0;
         color_acc = '0;
         r = blank_record(bhpd_pkg::KIND_HEADER);
         r.width = img_w[12:0];
         r.height = img_h[12:0];
         r.bpp = 3'(n_bits / 8);
      end
      return r;
   endfunction

   function automatic bit close_row();
      col_cnt = '0;
      row_cnt++;
      if (row_cnt >= img_h) begin
         ph = bhpd_pkg::PH_IDLE;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic deframe_byte(input logic [7:0] b, input logic sof, input logic eof);
      bhpd_pkg::result_type fresh[$];
      bhpd_pkg::result_type r;
      int unsigned          bpp_now;
      int unsigned          pad;
      if (eof) begin
         if (ph != bhpd_pkg::PH_IDLE) begin
            ph = bhpd_pkg::PH_IDLE;
            r = blank_record(bhpd_pkg::KIND_ERROR);
            r.err = bhpd_pkg::ERR_TRUNCATED;
            fresh.push_back(r);
         end
      end else begin
         if (sof) begin
            clear_parser();
            ph = bhpd_pkg::PH_FILEHDR;
         end
         case (ph)
            bhpd_pkg::PH_FILEHDR: begin
               if ((hdr_pos == 0 && b != bhpd_pkg::SIG_B) ||
                   (hdr_pos == 1 && b != bhpd_pkg::SIG_M))
                  sig_bad = 1'b1;
               if (hdr_pos >= 10 && hdr_pos <= 13)
                  data_ofs[(hdr_pos - 10) * 8 +: 8] = b;
               hdr_pos++;
               if (hdr_pos >= bhpd_pkg::FILE_HDR_LEN) begin
                  hdr_pos = 0;
                  ph = bhpd_pkg::PH_INFO;
               end
            end
            bhpd_pkg::PH_INFO: begin
               if (hdr_pos <= 3)
                  info_len[hdr_pos * 8 +: 8] = b;
               else if (hdr_pos <= 7)
                  img_w[(hdr_pos - 4) * 8 +: 8] = b;
               else if (hdr_pos <= 11)
                  img_h[(hdr_pos - 8) * 8 +: 8] = b;
               else if (hdr_pos <= 13)
                  n_planes[(hdr_pos - 12) * 8 +: 8] = b;
               else if (hdr_pos <= 15)
                  n_bits[(hdr_pos - 14) * 8 +: 8] = b;
               else if (hdr_pos >= bhpd_pkg::PALETTE_START && b != 0)
                  pal_bad = 1'b1;
               hdr_pos++;
               if (hdr_pos >= bhpd_pkg::INFO_HDR_LEN) begin
                  if (info_len > bhpd_pkg::INFO_HDR_LEN)
                     ph = bhpd_pkg::PH_SKIP;
                  else
                     fresh.push_back(judge_headers());
               end
            end
            bhpd_pkg::PH_SKIP: begin
               hdr_pos++;
               if (hdr_pos >= info_len)
                  fresh.push_back(judge_headers());
            end
            bhpd_pkg::PH_PIXELS: begin
               if (pad_cnt > 0) begin
                  pad_cnt--;
                  if (pad_cnt == 0 && close_row())
                     fresh.push_back(blank_record(bhpd_pkg::KIND_COMPLETE));
               end else begin
                  bpp_now = n_bits / 8;
                  color_acc = color_acc | (32'(b) << (byte_cnt * 8));
                  byte_cnt++;
                  if (byte_cnt >= bpp_now) begin
                     r = blank_record(bhpd_pkg::KIND_PIXEL);
                     r.column = col_cnt[11:0];
                     r.row = row_cnt[11:0];
                     r.color = color_acc;
                     fresh.push_back(r);
                     color_acc = '0;
                     byte_cnt = 0;
                     col_cnt++;
                     if (col_cnt >= img_w) begin
                        pad = (4 - ((img_w * bpp_now) & 3)) & 3;
                        if (pad != 0)
                           pad_cnt = pad;
                        else if (close_row())
                           fresh.push_back(blank_record(bhpd_pkg::KIND_COMPLETE));
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      foreach (fresh[i]) begin
         r = fresh[i];
         r.last = (i == fresh.size() - 1);
         decoded_items.push_back(r);
      end
   endtask

   task automatic push_byte(input logic [7:0] b, input logic sof, input logic eof);
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_start_of_file <= sof;
      req_end_of_file <= eof;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (ph != bhpd_pkg::PH_IDLE || (sof && !eof))
         busy_items++;
      deframe_byte(b, sof, eof);
   endtask

   function automatic bmp_header_type sound_header(int unsigned w, int unsigned ht,
                                                   int unsigned bits);
      bmp_header_type h;
      h.sig0 = bhpd_pkg::SIG_B;
      h.sig1 = bhpd_pkg::SIG_M;
      h.info_len = bhpd_pkg::INFO_HDR_LEN;
      h.offset = bhpd_pkg::FILE_HDR_LEN + bhpd_pkg::INFO_HDR_LEN;
      h.width = w;
      h.height = ht;
      h.planes = 16'd1;
      h.bits = 16'(bits);
      h.palette = '0;
      h.data_len = ht * (((w * bits / 8) + 3) / 4) * 4;
      return h;
   endfunction

   // A cut of zero or less sends the whole file; with_end appends an end of stream.
   task automatic stream_file(input bmp_header_type h, input int cut, input bit with_end);
      logic [7:0] bytes[$];
      int         n_send;
      bytes.push_back(h.sig0);
      bytes.push_back(h.sig1);
      repeat (8) bytes.push_back(8'($urandom));
      for (int i = 0; i < 4; i++) bytes.push_back(h.offset[i * 8 +: 8]);
      for (int i = 0; i < 4; i++) bytes.push_back(h.info_len[i * 8 +: 8]);
      for (int i = 0; i < 4; i++) bytes.push_back(h.width[i * 8 +: 8]);
      for (int i = 0; i < 4; i++) bytes.push_back(h.height[i * 8 +: 8]);
      for (int i = 0; i < 2; i++) bytes.push_back(h.planes[i * 8 +: 8]);
      for (int i = 0; i < 2; i++) bytes.push_back(h.bits[i * 8 +: 8]);
      repeat (16) bytes.push_back(8'($urandom));
      for (int i = 0; i < 8; i++) bytes.push_back(h.palette[i * 8 +: 8]);
      if (h.info_len > bhpd_pkg::INFO_HDR_LEN && h.info_len < 1024)
         repeat (h.info_len - bhpd_pkg::INFO_HDR_LEN) bytes.push_back(8'($urandom));
      repeat (h.data_len) bytes.push_back(8'($urandom));
      n_send = (cut > 0 && cut < bytes.size()) ? cut : bytes.size();
      for (int i = 0; i < n_send; i++) push_byte(bytes[i], i == 0, 1'b0);
      if (with_end)
         push_byte(8'($urandom), 1'($urandom), 1'b1);
   endtask

   task automatic test_stream_control();
      bmp_header_type h;
      push_byte(8'hA5, 1'b0, 1'b1);
      push_byte(8'h00, 1'b1, 1'b1);
      repeat (4) push_byte(8'($urandom), 1'b0, 1'b0);
      h = sound_header(2, 2, 24);
      stream_file(h, 5, 1);
      stream_file(h, 30, 1);
      stream_file(h, 54 + 2, 1);
      h = sound_header(1, 2, 24);
      stream_file(h, 54 + 3, 1);
      h.info_len = 48;
      h.offset = 62;
      stream_file(h, 50, 1);
      h = sound_header(3, 2, 32);
      stream_file(h, 10, 0);
      push_byte(8'hFF, 1'b1, 1'b1);
      stream_file(h, 30, 0);
      stream_file(h, 0, 0);
      repeat (5) push_byte(8'($urandom), 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b1);
   endtask

   task automatic test_good_files();
      bmp_header_type h;
      for (int w = 1; w <= 4; w++) begin
         stream_file(sound_header(w, 2, 24), 0, 0);
         stream_file(sound_header(w, 2, 32), 0, 0);
      end
      h = sound_header(3, 2, 24);
      h.info_len = 12;
      h.offset = 26;
      stream_file(h, 0, 0);
      h.info_len = 0;
      h.offset = 14;
      stream_file(h, 0, 0);
      h.info_len = 108;
      h.offset = 122;
      stream_file(h, 0, 0);
   endtask

   task automatic test_header_errors();
      bmp_header_type base;
      bmp_header_type h;
      base = sound_header(2, 2, 24);
      base.data_len = 4;
      h = base; h.sig0 = 8'h4D; stream_file(h, 0, 0);
      h = base; h.sig1 = 8'h42; stream_file(h, 0, 0);
      h = base; h.offset = 55; stream_file(h, 0, 0);
      h = base; h.info_len = 12; stream_file(h, 0, 0);
      h = base; h.planes = 16'd0; stream_file(h, 0, 0);
      h = base; h.planes = 16'h0101; stream_file(h, 0, 0);
      h = base; h.bits = 16'd16; stream_file(h, 0, 0);
      h = base; h.bits = 16'd0; stream_file(h, 0, 0);
      h = base; h.bits = 16'h0118; stream_file(h, 0, 0);
      h = base; h.palette[7:0] = 8'h01; stream_file(h, 0, 0);
      h = base; h.palette[63:56] = 8'h80; stream_file(h, 0, 0);
      h = base; h.sig0 = 8'h00; h.planes = 16'd2; stream_file(h, 0, 0);
      h = base; h.offset = 0; h.width = 0; stream_file(h, 0, 0);
      h = base; h.planes = 16'd3; h.bits = 16'd8; stream_file(h, 0, 0);
      h = base; h.bits = 16'd48; h.palette = '1; stream_file(h, 0, 0);
   endtask

   task automatic test_size_extremes();
      bmp_header_type base;
      bmp_header_type h;
      base = sound_header(2, 2, 24);
      base.data_len = 4;
      h = base; h.width = 0; stream_file(h, 0, 0);
      h = base; h.height = 0; stream_file(h, 0, 0);
      h = base; h.width = MAX_W + 1; stream_file(h, 0, 0);
      h = base; h.height = MAX_H + 1; stream_file(h, 0, 0);
      h = base; h.width = 32'hFFFF_FFFF; stream_file(h, 0, 0);
      h = base; h.height = 32'h8000_0000; stream_file(h, 0, 0);
      stream_file(sound_header(MAX_W, MAX_H, 32), 54 + 8, 1);
      stream_file(sound_header(MAX_W, 1, 32), 54 + 8, 1);
      stream_file(sound_header(1, MAX_H, 24), 54 + 8, 1);
   endtask

   task automatic test_random_files(input int target);
      bmp_header_type h;
      int             pick;
      int unsigned    w;
      busy_items = 0;
      while (busy_items < target) begin
         w = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 9);
         h = sound_header(w, $urandom_range(1, 4), $urandom_range(0, 1) ? 24 : 32);
         if ($urandom_range(0, 3) == 0) begin
            h.info_len = bhpd_pkg::INFO_HDR_LEN + $urandom_range(1, 24);
            h.offset = h.info_len + bhpd_pkg::FILE_HDR_LEN;
         end
         pick = $urandom_range(0, 19);
         if (pick < 13) begin
            stream_file(h, 0, $urandom_range(0, 3) == 0);
         end else if (pick < 15) begin
            stream_file(h, $urandom_range(1, 54 + h.data_len), 1);
         end else if (pick < 18) begin
            if ($urandom_range(0, 3) == 0) h.sig0 = 8'($urandom);
            if ($urandom_range(0, 3) == 0) h.sig1 = 8'($urandom);
            if ($urandom_range(0, 3) == 0) h.offset = h.offset + $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) h.width = $urandom_range(0, 1) ? 0 : $urandom;
            if ($urandom_range(0, 3) == 0) h.height = $urandom_range(0, 1) ? 0 : $urandom;
            if ($urandom_range(0, 3) == 0) h.planes = 16'($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0) h.bits = 16'($urandom_range(0, 40));
            if ($urandom_range(0, 3) == 0)
               h.palette[8 * $urandom_range(0, 7) +: 8] = 8'($urandom_range(1, 255));
            h.data_len = $urandom_range(0, 8);
            stream_file(h, 0, 0);
         end else begin
            repeat ($urandom_range(1, 20))
               push_byte(8'($urandom), $urandom_range(0, 15) == 0, $urandom_range(0, 31) == 0);
         end
      end
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   task automatic match_record();
      bhpd_pkg::result_type want;
      if (decoded_items.size() == 0) begin
         $error("unexpected result item of kind %0d", rsp_kind);
         error_count++;
      end else begin
         want = decoded_items.pop_front();
         check_field("kind", want.kind, rsp_kind);
         check_field("pixel_column", want.column, rsp_pixel_column);
         check_field("pixel_row", want.row, rsp_pixel_row);
         check_field("pixel_color", want.color, rsp_pixel_color);
         check_field("image_width", want.width, rsp_image_width);
         check_field("image_height", want.height, rsp_image_height);
         check_field("bytes_per_pixel", want.bpp, rsp_bytes_per_pixel);
         check_field("error_code", want.err, rsp_error_code);
         check_field("last", want.last, rsp_last);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         match_record();
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!reset && idling_on && !rsp_stall && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      clear_parser();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      idling_on = 1'b1;
      test_stream_control();
      test_good_files();
      test_header_errors();
      test_size_extremes();
      test_random_files(150);
      idling_on = 1'b0;
      test_random_files(150);
      req_valid <= 1'b0;
      while (decoded_items.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (error_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
